// ===== rtl/core/ca3d_pkg.sv =====
// Shared types and constants for the 3D cellular automaton step core.
package ca3d_pkg;
  localparam int MaxDim = 16;
  localparam int CoordW = $clog2(MaxDim);
  localparam int DimW = 5;
  localparam int Cells = MaxDim * MaxDim * MaxDim;
  localparam int AddrW = 3 * CoordW;
  localparam int LiveW = 13;
  localparam logic [3:0] AgeMax = 4'd11;
  localparam logic [LiveW-1:0] LiveMax = '1;

  localparam logic [1:0] ReqWrite = 2'd0;
  localparam logic [1:0] ReqRead = 2'd1;
  localparam logic [1:0] ReqStep = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic wr_cell;      // host write into current grid
    logic rd_cell;      // host read of current grid
    logic clr_mem;      // clear sweep write
    logic calc_start;   // begin neighbor scan of a cell
    logic calc_tap;     // sample one neighbor
    logic calc_store;   // write next value
    logic copy_rd;      // issue read of next grid
    logic copy_wr;      // commit into current grid
    logic clr_count;
    logic addr_clear;
  } ctl_t;

  function automatic logic [3:0] next_cell(input logic [3:0] s, input logic [4:0] c);
    logic [3:0] nx;
    nx = 4'd0;
    if (s != 4'd0) begin
      if (c > 5'd4) nx = s + 4'd1;
      if (c >= 5'd11 && c <= 5'd14) nx = 4'd0;
    end else if (c == 5'd10 || c == 5'd11) begin
      nx = 4'd1;
    end
    if (s > 4'd10) nx = s >> 1;
    return nx;
  endfunction
endpackage

// ===== rtl/core/ca3d_datapath.sv =====
// Datapath: grid memories, cell and neighbor address counters, neighbor counter.
module ca3d_datapath import ca3d_pkg::*; (
  input  logic              clk,
  input  ctl_t              ctl,
  input  logic [CoordW-1:0] pos_h,
  input  logic [CoordW-1:0] pos_w,
  input  logic [CoordW-1:0] pos_l,
  input  logic [3:0]        write_value,
  input  logic [CoordW:0]   dim_h,
  input  logic [CoordW:0]   dim_w,
  input  logic [CoordW:0]   dim_l,
  output logic              tap_last,
  output logic              cell_last,
  output logic [3:0]        rd_data,
  output logic [LiveW-1:0]  live_count
);
  logic [3:0] cur_mem [Cells];
  logic [3:0] nxt_mem [Cells];
  logic [CoordW-1:0] ch, cw, cl;      // cell being worked on
  logic [1:0] dh, dw, dl;             // neighbor offset, 0..2 stands for -1..+1
  logic [4:0] nbr;                    // live neighbor count
  logic [4:0] nbr_total;
  logic       tail_live;
  logic [3:0] self_v;
  logic [3:0] cur_q, nxt_q;
  logic       prev_valid, prev_self;
  logic [AddrW-1:0] clr_addr;

  logic [CoordW:0] nh, nw, nl;
  logic in_grid;
  logic [AddrW-1:0] nbr_addr, cell_addr, host_addr, rd_addr;

  assign nh = {1'b0, ch} + (CoordW+1)'(dh) - 1'b1;
  assign nw = {1'b0, cw} + (CoordW+1)'(dw) - 1'b1;
  assign nl = {1'b0, cl} + (CoordW+1)'(dl) - 1'b1;
  // wrap below zero gives a large value, caught by the compare
  assign in_grid = nh < dim_h && nw < dim_w && nl < dim_l;
  assign nbr_addr = {nh[CoordW-1:0], nw[CoordW-1:0], nl[CoordW-1:0]};
  assign cell_addr = {ch, cw, cl};
  assign host_addr = {pos_h, pos_w, pos_l};
  assign tap_last = dh == 2'd2 && dw == 2'd2 && dl == 2'd2;
  assign cell_last = ({1'b0, ch} == dim_h - 1'b1) && ({1'b0, cw} == dim_w - 1'b1)
                  && ({1'b0, cl} == dim_l - 1'b1);
  assign rd_data = cur_q;
  // last tap is still in cur_q when the store happens
  assign tail_live = prev_valid && !prev_self && cur_q != 4'd0;
  assign nbr_total = nbr + 5'(tail_live);

  always_comb begin
    rd_addr = host_addr;
    if (ctl.calc_tap) rd_addr = nbr_addr;
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_cell || ctl.calc_tap) cur_q <= cur_mem[rd_addr];
    if (ctl.copy_rd) nxt_q <= nxt_mem[cell_addr];
    if (ctl.clr_mem) cur_mem[clr_addr] <= 4'd0;
    else if (ctl.wr_cell)
      cur_mem[host_addr] <= (write_value > AgeMax) ? AgeMax : write_value;
    else if (ctl.copy_wr) cur_mem[cell_addr] <= nxt_q;
    if (ctl.calc_store) nxt_mem[cell_addr] <= next_cell(self_v, nbr_total);
  end

  always_ff @(posedge clk) begin
    if (ctl.addr_clear) begin
      ch <= '0; cw <= '0; cl <= '0; clr_addr <= '0;
    end else if (ctl.clr_mem) begin
      clr_addr <= clr_addr + 1'b1;
    end else if (ctl.calc_store || ctl.copy_wr) begin
      if ({1'b0, cl} != dim_l - 1'b1) cl <= cl + 1'b1;
      else begin
        cl <= '0;
        if ({1'b0, cw} != dim_w - 1'b1) cw <= cw + 1'b1;
        else begin
          cw <= '0;
          ch <= ({1'b0, ch} != dim_h - 1'b1) ? ch + 1'b1 : '0;
        end
      end
    end
    // neighbor scan: one memory read per tap; each tap's value is counted at the next tap, the last at the store
    if (ctl.calc_start) begin
      dh <= '0; dw <= '0; dl <= '0; nbr <= '0; prev_valid <= 1'b0; prev_self <= 1'b0;
    end else if (ctl.calc_tap) begin
      if (tail_live) nbr <= nbr + 1'b1;
      if (prev_valid && prev_self) self_v <= cur_q;
      prev_valid <= in_grid;
      prev_self <= dh == 2'd1 && dw == 2'd1 && dl == 2'd1;
      if (!tap_last) begin
        if (dl != 2'd2) dl <= dl + 1'b1;
        else begin
          dl <= '0;
          if (dw != 2'd2) dw <= dw + 1'b1;
          else begin
            dw <= '0;
            dh <= dh + 1'b1;
          end
        end
      end
    end
    if (ctl.clr_count) live_count <= '0;
    else if (ctl.copy_wr && nxt_q != 4'd0 && live_count != LiveMax)
      live_count <= live_count + 1'b1;
  end
endmodule

// ===== rtl/core/ca3d_ctrl.sv =====
// Controller: request decode and sequencing of clear, step and commit.
module ca3d_ctrl import ca3d_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] req_type,
  input  logic       in_range,
  input  logic       tap_last,
  input  logic       cell_last,
  output logic       busy,
  output ctl_t       ctl,
  output logic       done,
  output logic       out_of_range,
  output logic       show_read,
  output logic       show_count
);
  typedef enum logic [2:0] {S_CLR, S_IDLE, S_READ, S_TAP, S_STORE, S_CRD, S_CWR} state_t;
  state_t state;
  logic [AddrW-1:0] clr_n;
  logic go;

  assign go = start && !busy;
  assign busy = state != S_IDLE;

  always_comb begin
    ctl = '0;
    ctl.clr_mem = state == S_CLR;
    ctl.wr_cell = go && req_type == ReqWrite && in_range;
    ctl.rd_cell = go && req_type == ReqRead;
    ctl.addr_clear = go || rst;
    ctl.clr_count = go;
    ctl.calc_start = (go && req_type == ReqStep) || state == S_STORE;
    ctl.calc_tap = state == S_TAP;
    ctl.calc_store = state == S_STORE;
    ctl.copy_rd = state == S_CRD;
    ctl.copy_wr = state == S_CWR;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR; clr_n <= '0; done <= 1'b0; out_of_range <= 1'b0;
      show_read <= 1'b0; show_count <= 1'b0;
    end else begin
      done <= 1'b0; out_of_range <= 1'b0; show_read <= 1'b0; show_count <= 1'b0;
      case (state)
        S_CLR: begin
          clr_n <= clr_n + 1'b1;
          if (clr_n == '1) state <= S_IDLE;
        end
        S_IDLE: if (start) begin
          case (req_type)
            ReqWrite: begin done <= 1'b1; out_of_range <= !in_range; end
            ReqRead: begin
              if (in_range) state <= S_READ;
              else begin done <= 1'b1; out_of_range <= 1'b1; end
            end
            ReqStep: state <= S_TAP;
            default: done <= 1'b1;
          endcase
        end
        S_READ: begin done <= 1'b1; show_read <= 1'b1; state <= S_IDLE; end
        S_TAP: if (tap_last) state <= S_STORE;
        S_STORE: state <= cell_last ? S_CRD : S_TAP;
        S_CRD: state <= S_CWR;
        S_CWR: if (cell_last) begin
          done <= 1'b1; show_count <= 1'b1; state <= S_IDLE;
        end else state <= S_CRD;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/cellular_automaton_3d_step_core.sv =====
// Top level of the 3D cellular automaton step core.
//  channel   | handshake          | word
//  request   | start / busy       | req_type, pos_h, pos_w, pos_l, write_value
//  config    | cfg_valid/cfg_ready| cfg_index, cfg_data
//  result    | done (strobe)      | read_value, live_cells, out_of_range
// Read answers come from a registered memory read.
// Step: per cell in use, 27 neighbor reads (one memory read port) and a store,
// then a commit pass that reads and writes back each cell in use.
// After reset the grid is cleared, one cell a cycle, all 4096 cells, with busy high.
// Results are strobed for one cycle; the receiver cannot stall.
module cellular_automaton_3d_step_core import ca3d_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       req_type,
  input  logic [3:0]       pos_h,
  input  logic [3:0]       pos_w,
  input  logic [3:0]       pos_l,
  input  logic [3:0]       write_value,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [DimW-1:0]  cfg_data,
  output logic             done,
  output logic [3:0]       read_value,
  output logic [LiveW-1:0] live_cells,
  output logic             out_of_range
);
  logic [CoordW:0] dim_h, dim_w, dim_l, dim_v;
  logic in_range, tap_last, cell_last, show_read, show_count;
  logic [3:0] rd_data;
  logic [LiveW-1:0] live_count;
  ctl_t ctl;

  assign cfg_ready = 1'b1;
  assign dim_v = (cfg_data == '0) ? (CoordW+1)'(1) :
                 (cfg_data > DimW'(MaxDim)) ? (CoordW+1)'(MaxDim) : cfg_data[CoordW:0];
  assign in_range = {1'b0, pos_h} < dim_h && {1'b0, pos_w} < dim_w
                 && {1'b0, pos_l} < dim_l;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_h <= (CoordW+1)'(MaxDim); dim_w <= (CoordW+1)'(MaxDim);
      dim_l <= (CoordW+1)'(MaxDim);
    end else if (cfg_valid) begin
      if (cfg_index == 2'd0) dim_h <= dim_v;
      if (cfg_index == 2'd1) dim_w <= dim_v;
      if (cfg_index == 2'd2) dim_l <= dim_v;
    end
  end

  ca3d_ctrl u_ctrl (
    .clk, .rst, .start, .req_type, .in_range, .tap_last, .cell_last, .busy, .ctl,
    .done, .out_of_range, .show_read, .show_count
  );

  ca3d_datapath u_dp (
    .clk, .ctl, .pos_h, .pos_w, .pos_l, .write_value, .dim_h, .dim_w, .dim_l,
    .tap_last, .cell_last, .rd_data, .live_count
  );

  assign read_value = show_read ? rd_data : 4'd0;
  assign live_cells = show_count ? live_count : '0;
endmodule

// ===== dv/cellular_automaton_3d_step_core_test.sv =====
// Testbench for the 3D cellular automaton step core: directed and random requests, checked per word.
module cellular_automaton_3d_step_core_test import ca3d_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchLimit = 500000;
  localparam logic [1:0] ReqUnused = 2'd3;
  localparam logic [1:0] CfgHeight = 2'd0;
  localparam logic [1:0] CfgWidth = 2'd1;
  localparam logic [1:0] CfgLength = 2'd2;
  localparam logic [1:0] CfgSpare = 2'd3;

  typedef struct {
    logic [3:0]       read_value;
    logic [LiveW-1:0] live_cells;
    logic             out_of_range;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] req_type = '0;
  logic [3:0] pos_h = '0, pos_w = '0, pos_l = '0, write_value = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [DimW-1:0] cfg_data = '0;
  logic done;
  logic [3:0] read_value;
  logic [LiveW-1:0] live_cells;
  logic out_of_range;

  logic [3:0] grid_model [Cells];
  int dim_h = MaxDim, dim_w = MaxDim, dim_l = MaxDim;
  answer_t pending_answers[$];
  int errors = 0;
  int idle_cycles = 0;

  cellular_automaton_3d_step_core u_dut (.*);

  always #6 clk = ~clk;

  function automatic int cell_index(int h, int w, int l);
    return (h * MaxDim + w) * MaxDim + l;
  endfunction

  function automatic int live_neighbors(int h, int w, int l);
    int n = 0;
    for (int dh = -1; dh <= 1; dh++)
      for (int dw = -1; dw <= 1; dw++)
        for (int dl = -1; dl <= 1; dl++) begin
          if (dh == 0 && dw == 0 && dl == 0) continue;
          if (h + dh < 0 || h + dh >= dim_h) continue;
          if (w + dw < 0 || w + dw >= dim_w) continue;
          if (l + dl < 0 || l + dl >= dim_l) continue;
          if (grid_model[cell_index(h + dh, w + dw, l + dl)] != 4'd0) n++;
        end
    return n;
  endfunction

  function automatic logic [3:0] age_cell(logic [3:0] s, int c);
    logic [3:0] nx = 4'd0;
    if (s != 4'd0) begin
      if (c > 4) nx = s + 4'd1;
      if (c >= 11 && c <= 14) nx = 4'd0;
    end else if (c == 10 || c == 11) begin
      nx = 4'd1;
    end
    if (s > 4'd10) nx = s >> 1;
    return nx;
  endfunction

  function automatic logic [LiveW-1:0] advance_generation();
    logic [3:0] nxt [Cells];
    int live = 0;
    for (int h = 0; h < dim_h; h++)
      for (int w = 0; w < dim_w; w++)
        for (int l = 0; l < dim_l; l++)
          nxt[cell_index(h, w, l)] = age_cell(grid_model[cell_index(h, w, l)],
                                              live_neighbors(h, w, l));
    for (int h = 0; h < dim_h; h++)
      for (int w = 0; w < dim_w; w++)
        for (int l = 0; l < dim_l; l++) begin
          grid_model[cell_index(h, w, l)] = nxt[cell_index(h, w, l)];
          if (nxt[cell_index(h, w, l)] != 4'd0) live++;
        end
    return (live > int'(LiveMax)) ? LiveMax : LiveW'(live);
  endfunction

  function automatic answer_t serve_request(logic [1:0] rq, int h, int w, int l,
                                            logic [3:0] v);
    answer_t a = '{default: '0};
    logic in_range = h < dim_h && w < dim_w && l < dim_l;
    case (rq)
      ReqWrite: begin
        if (in_range) grid_model[cell_index(h, w, l)] = (v > AgeMax) ? AgeMax : v;
        else a.out_of_range = 1'b1;
      end
      ReqRead: begin
        if (in_range) a.read_value = grid_model[cell_index(h, w, l)];
        else a.out_of_range = 1'b1;
      end
      ReqStep: a.live_cells = advance_generation();
      default: ;
    endcase
    return a;
  endfunction

  task automatic report(string what, int exp_v, int got_v);
    $display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    answer_t e;
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        report("unexpected word", 0, 1);
      end else begin
        e = pending_answers.pop_front();
        if (read_value !== e.read_value) report("read_value", e.read_value, read_value);
        if (live_cells !== e.live_cells) report("live_cells", e.live_cells, live_cells);
        if (out_of_range !== e.out_of_range)
          report("out_of_range", e.out_of_range, out_of_range);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // called at a rising edge; leaves start high so back-to-back words need no toggle
  task automatic send_request(logic [1:0] rq, int h, int w, int l, int v);
    answer_t a;
    start <= 1'b1;
    req_type <= rq;
    pos_h <= 4'(h);
    pos_w <= 4'(w);
    pos_l <= 4'(l);
    write_value <= 4'(v);
    do @(posedge clk); while (busy);
    a = serve_request(rq, h, w, l, 4'(v));
    pending_answers = {pending_answers, a};
  endtask

  task automatic pause();
    int n;
    int r = $urandom_range(99);
    if (r < 65) return;
    n = (r < 95) ? $urandom_range(3, 1) : $urandom_range(40, 10);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic write_dim(logic [1:0] idx, int val);
    int c;
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= DimW'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    c = (val < 1) ? 1 : (val > MaxDim) ? MaxDim : val;
    case (idx)
      CfgHeight: dim_h = c;
      CfgWidth: dim_w = c;
      CfgLength: dim_l = c;
      default: ;
    endcase
  endtask

  task automatic set_dims(int h, int w, int l);
    write_dim(CfgHeight, h);
    write_dim(CfgWidth, w);
    write_dim(CfgLength, l);
    @(posedge clk);
  endtask

  // full 16^3 grid: corners, saturation, one generation over every cell
  task automatic test_full_grid();
    send_request(ReqRead, 0, 0, 0, 0);
    send_request(ReqRead, 15, 15, 15, 0);
    send_request(ReqWrite, 15, 15, 15, 15);
    send_request(ReqWrite, 0, 0, 0, 12);
    send_request(ReqRead, 15, 15, 15, 0);
    send_request(ReqWrite, 0, 0, 1, 10);
    for (int i = 0; i < 5; i++) send_request(ReqWrite, 1, i % 2, i / 2, 3);
    send_request(ReqStep, 0, 0, 0, 0);
    send_request(ReqRead, 0, 0, 0, 0);
    send_request(ReqUnused, 15, 15, 15, 15);
  endtask

  // dimension clamping, spare index, out-of-range coordinates
  task automatic test_dims_and_range();
    write_dim(CfgSpare, 3);
    set_dims(0, 31, 17);
    send_request(ReqWrite, 1, 15, 15, 7);
    send_request(ReqRead, 0, 15, 15, 0);
    send_request(ReqRead, 0, 0, 0, 0);
    send_request(ReqStep, 9, 9, 9, 9);
    set_dims(3, 2, 4);
    send_request(ReqWrite, 2, 1, 4, 5);
    send_request(ReqRead, 3, 0, 0, 0);
    send_request(ReqRead, 2, 1, 3, 0);
    send_request(ReqStep, 0, 0, 0, 0);
  endtask

  task automatic test_random();
    int items = 0;
    int h, w, l, r;
    while (items < 140) begin
      r = $urandom_range(9);
      h = (r == 0) ? MaxDim : $urandom_range(5, 1);
      w = (r == 1) ? MaxDim : $urandom_range(5, 1);
      l = (r == 2) ? MaxDim : $urandom_range(5, 1);
      set_dims(h, w, l);
      for (int i = 0; i < 20; i++) begin
        r = $urandom_range(99);
        if (r < 55)
          send_request(ReqWrite, $urandom_range(dim_h - 1), $urandom_range(dim_w - 1),
                       $urandom_range(dim_l - 1),
                       ($urandom_range(9) < 7) ? $urandom_range(15, 1) : 0);
        else if (r < 75)
          send_request(ReqRead, $urandom_range(dim_h - 1), $urandom_range(dim_w - 1),
                       $urandom_range(dim_l - 1), $urandom_range(15));
        else if (r < 85)
          send_request(ReqStep, $urandom_range(15), $urandom_range(15),
                       $urandom_range(15), $urandom_range(15));
        else if (r < 97)
          send_request(($urandom_range(1) != 0) ? ReqRead : ReqWrite,
                       $urandom_range(15), $urandom_range(15), $urandom_range(15),
                       $urandom_range(15));
        else
          send_request(ReqUnused, $urandom_range(15), $urandom_range(15),
                       $urandom_range(15), $urandom_range(15));
        items++;
        pause();
      end
    end
  endtask

  initial begin
    for (int i = 0; i < Cells; i++) grid_model[i] = 4'd0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_full_grid();
    test_dims_and_range();
    test_random();
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/ca3d_pkg.sv
rtl/core/ca3d_datapath.sv
rtl/core/ca3d_ctrl.sv
rtl/core/cellular_automaton_3d_step_core.sv
dv/cellular_automaton_3d_step_core_test.sv
